[rtl/core/cst_pkg.sv]
// Shared types, codes and defaults for the counting semaphore table.
package cst_pkg;

    localparam int SEM_SLOTS_DEF    = 16;
    localparam int WAITER_SLOTS_DEF = 16;

    localparam logic [15:0] COUNT_MAX = 16'hFFFF;

    localparam logic [1:0] OP_OPEN  = 2'd0;
    localparam logic [1:0] OP_CLOSE = 2'd1;
    localparam logic [1:0] OP_POST  = 2'd2;
    localparam logic [1:0] OP_WAIT  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_BLOCKED   = 3'd2;
    localparam logic [2:0] ST_NO_WAITER = 3'd3;
    localparam logic [2:0] ST_UNUSED    = 3'd4;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] name_key;
        logic [3:0]  target_id;
        logic [7:0]  caller_pid;
        logic        caller_can_block;
    } cst_cmd_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] result_id;
        logic       wake_valid;
        logic [7:0] wake_pid;
        logic       block_valid;
        logic       yield_request;
    } cst_rsp_t;

endpackage

[rtl/core/cst_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/counting_semaphore_table.sv]
// Top level of the counting semaphore table: sequencer, slot table and waiter store.
//
//   channel | direction | handshake          | payload
//   cmd     | in        | cmd_valid/cmd_stall | cst_cmd_t
//   rsp     | out       | rsp_valid/rsp_stall | cst_rsp_t
//
// One item is worked on at a time; cmd_stall is high from acceptance until the result is stored.
// Open scans slots for a free or matching name, then clears the waiter row of the chosen slot.
// Post and a zero-count wait scan the waiter row after the count; close and unused ids skip both.
// All scans run through one shared compare and one port of each RAM; no clearing pass follows reset.
// A result waits in the output register while rsp_stall is high, and the next item may be accepted.
module counting_semaphore_table
    import cst_pkg::*;
#(
    parameter int SEM_SLOTS    = SEM_SLOTS_DEF,
    parameter int WAITER_SLOTS = WAITER_SLOTS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     cmd_valid,
    output logic     cmd_stall,
    input  cst_cmd_t cmd,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output cst_rsp_t rsp
);

    localparam int SEM_W     = (SEM_SLOTS > 1) ? $clog2(SEM_SLOTS) : 1;
    localparam int WAIT_W    = (WAITER_SLOTS > 1) ? $clog2(WAITER_SLOTS) : 1;
    localparam int TOTAL     = SEM_SLOTS * WAITER_SLOTS;
    localparam int WADDR_W   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int SLOT_DW   = 80;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_DECODE   = 4'd1;
    localparam logic [3:0] S_SCAN_RD  = 4'd2;
    localparam logic [3:0] S_SCAN_CHK = 4'd3;
    localparam logic [3:0] S_CLEAR    = 4'd4;
    localparam logic [3:0] S_CNT_RD   = 4'd5;
    localparam logic [3:0] S_CNT      = 4'd6;
    localparam logic [3:0] S_W_RD     = 4'd7;
    localparam logic [3:0] S_W_CHK    = 4'd8;
    localparam logic [3:0] S_OUT      = 4'd9;

    logic [3:0]           state_reg, state_next;
    logic [SEM_SLOTS-1:0] in_use_reg, in_use_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    cst_cmd_t             cmd_reg, cmd_next;
    cst_rsp_t             res_reg, res_next;
    cst_rsp_t             rsp_reg, rsp_next;
    logic [SEM_W-1:0]     idx_reg, idx_next;
    logic [WAIT_W-1:0]    w_reg, w_next;

    logic                 slot_we;
    logic [SLOT_DW-1:0]   slot_wdata;
    logic [SLOT_DW-1:0]   slot_rdata;
    logic                 wt_we;
    logic [8:0]           wt_wdata;
    logic [8:0]           wt_rdata;
    logic [WADDR_W-1:0]   wt_addr;

    logic [63:0]          rd_key;
    logic [15:0]          rd_cnt;
    logic [8:0]           tid_wide;
    logic                 id_ok;
    logic                 idx_last;
    logic                 w_last;
    logic                 cmd_take;

    assign rd_key   = slot_rdata[79:16];
    assign rd_cnt   = slot_rdata[15:0];
    assign tid_wide = 9'(cmd_reg.target_id);
    assign id_ok    = tid_wide < 9'(SEM_SLOTS);
    assign idx_last = idx_reg == SEM_W'(SEM_SLOTS - 1);
    assign w_last   = w_reg == WAIT_W'(WAITER_SLOTS - 1);
    assign wt_addr  = WADDR_W'(idx_reg) * WADDR_W'(WAITER_SLOTS) + WADDR_W'(w_reg);
    assign cmd_take = cmd_valid && !cmd_stall;

    cst_ram #(
        .WIDTH (SLOT_DW),
        .DEPTH (SEM_SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (idx_reg),
        .wdata (slot_wdata),
        .raddr (idx_reg),
        .rdata (slot_rdata)
    );

    cst_ram #(
        .WIDTH (9),
        .DEPTH (TOTAL)
    ) u_waiter_ram (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_addr),
        .wdata (wt_wdata),
        .raddr (wt_addr),
        .rdata (wt_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        in_use_next    = in_use_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        idx_next       = idx_reg;
        w_next         = w_reg;
        slot_we        = 1'b0;
        slot_wdata     = {rd_key, rd_cnt};
        wt_we          = 1'b0;
        wt_wdata       = 9'd0;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    cmd_next   = cmd;
                    res_next   = '0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                w_next = '0;
                if (cmd_reg.operation == OP_OPEN)
                begin
                    idx_next   = '0;
                    state_next = S_SCAN_RD;
                end
                else if (!id_ok || !in_use_reg[tid_wide[SEM_W-1:0]])
                begin
                    res_next.status = ST_UNUSED;
                    state_next      = S_OUT;
                end
                else if (cmd_reg.operation == OP_CLOSE)
                begin
                    in_use_next[tid_wide[SEM_W-1:0]] = 1'b0;
                    state_next = S_OUT;
                end
                else
                begin
                    idx_next   = tid_wide[SEM_W-1:0];
                    state_next = S_CNT_RD;
                end
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (!in_use_reg[idx_reg] || rd_key == cmd_reg.name_key)
                begin
                    slot_we              = 1'b1;
                    slot_wdata           = {cmd_reg.name_key, 16'd1};
                    in_use_next[idx_reg] = 1'b1;
                    res_next.result_id   = 4'(idx_reg);
                    w_next               = '0;
                    state_next           = S_CLEAR;
                end
                else if (idx_last)
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_OUT;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_SCAN_RD;
                end
            end
            S_CLEAR:
            begin
                wt_we = 1'b1;
                if (w_last)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    w_next = w_reg + 1'b1;
                end
            end
            S_CNT_RD:
            begin
                state_next = S_CNT;
            end
            S_CNT:
            begin
                if (cmd_reg.operation == OP_POST)
                begin
                    slot_we = 1'b1;
                    if (rd_cnt != COUNT_MAX)
                    begin
                        slot_wdata = {rd_key, rd_cnt + 16'd1};
                    end
                    state_next = S_W_RD;
                end
                else if (rd_cnt != 16'd0)
                begin
                    slot_we    = 1'b1;
                    slot_wdata = {rd_key, rd_cnt - 16'd1};
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_W_RD;
                end
            end
            S_W_RD:
            begin
                state_next = S_W_CHK;
            end
            S_W_CHK:
            begin
                if (cmd_reg.operation == OP_POST && wt_rdata[8])
                begin
                    wt_we               = 1'b1;
                    res_next.wake_valid = 1'b1;
                    res_next.wake_pid   = wt_rdata[7:0];
                    state_next          = S_OUT;
                end
                else if (cmd_reg.operation == OP_WAIT && !wt_rdata[8])
                begin
                    res_next.yield_request = 1'b1;
                    if (cmd_reg.caller_can_block)
                    begin
                        wt_we                = 1'b1;
                        wt_wdata             = {1'b1, cmd_reg.caller_pid};
                        res_next.block_valid = 1'b1;
                        res_next.status      = ST_BLOCKED;
                    end
                    state_next = S_OUT;
                end
                else if (w_last)
                begin
                    if (cmd_reg.operation == OP_WAIT)
                    begin
                        res_next.status = ST_NO_WAITER;
                    end
                    state_next = S_OUT;
                end
                else
                begin
                    w_next     = w_reg + 1'b1;
                    state_next = S_W_RD;
                end
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = res_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            in_use_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            in_use_reg    <= in_use_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        res_reg <= res_next;
        rsp_reg <= rsp_next;
        idx_reg <= idx_next;
        w_reg   <= w_next;
    end

    assign cmd_stall = state_reg != S_IDLE;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_wake_xor_block: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.wake_valid && rsp.block_valid))
        else $error("wake and block reported for the same item");

    a_block_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.block_valid |-> rsp.status == ST_BLOCKED && rsp.yield_request)
        else $error("blocked caller without blocked status and yield");

    a_out_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT && state_next == S_IDLE |=> rsp_valid)
        else $error("finished item did not reach the output register");

    a_slot_in_use: assert property (@(posedge clk) disable iff (!rst_n)
        slot_we |=> in_use_reg[$past(idx_reg)])
        else $error("slot written without being in use");

endmodule

[dv/counting_semaphore_table_tb.sv]
// Self-checking testbench for the counting semaphore table with random idling and stalls.
`timescale 1ns / 100ps

module counting_semaphore_table_tb;
    import cst_pkg::*;

    localparam int SEM_SLOTS      = SEM_SLOTS_DEF;
    localparam int WAITER_SLOTS   = WAITER_SLOTS_DEF;
    localparam int CLK_PERIOD     = 12;
    localparam int KEY_POOL       = 24;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES   = 64;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int MAX_REPORTS    = 10;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     cmd_valid = 1'b0;
    logic     cmd_stall;
    cst_cmd_t cmd       = '0;
    logic     rsp_valid;
    logic     rsp_stall = 1'b0;
    cst_rsp_t rsp;

    cst_cmd_t    pending_cmds [$];
    cst_rsp_t    expected_rsp [$];
    logic [63:0] key_pool [KEY_POOL];

    bit          sem_in_use   [SEM_SLOTS];
    logic [63:0] sem_key      [SEM_SLOTS];
    logic [15:0] sem_count    [SEM_SLOTS];
    bit          waiter_busy  [SEM_SLOTS][WAITER_SLOTS];
    logic [7:0]  waiter_owner [SEM_SLOTS][WAITER_SLOTS];

    int   send_idle_pct = 0;
    int   rx_stall_pct  = 0;
    logic rx_hold       = 1'b0;
    int   fail_count    = 0;
    int   rsp_count     = 0;
    event rx_hold_start;

    counting_semaphore_table i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Applies one item to the shadow table and returns the result it must produce.
    function automatic cst_rsp_t semaphore_apply(cst_cmd_t c);
        cst_rsp_t r;
        int       hit;
        int       free_w;
        int       s;
        int       w;
        int       id;
        r      = '0;
        hit    = -1;
        free_w = -1;
        id     = int'(c.target_id);
        if (c.operation == OP_OPEN)
        begin
            for (s = 0; s < SEM_SLOTS; s++)
            begin
                if (hit < 0 && (!sem_in_use[s] || sem_key[s] == c.name_key))
                begin
                    hit = s;
                end
            end
            if (hit < 0)
            begin
                r.status = ST_FULL;
            end
            else
            begin
                sem_in_use[hit] = 1'b1;
                sem_key[hit]    = c.name_key;
                sem_count[hit]  = 16'd1;
                for (w = 0; w < WAITER_SLOTS; w++)
                begin
                    waiter_busy[hit][w] = 1'b0;
                end
                r.status    = ST_OK;
                r.result_id = hit[3:0];
            end
        end
        else if (id >= SEM_SLOTS || !sem_in_use[id])
        begin
            r.status = ST_UNUSED;
        end
        else if (c.operation == OP_CLOSE)
        begin
            for (w = 0; w < WAITER_SLOTS; w++)
            begin
                waiter_busy[id][w] = 1'b0;
            end
            sem_in_use[id] = 1'b0;
            r.status       = ST_OK;
        end
        else if (c.operation == OP_POST)
        begin
            if (sem_count[id] != COUNT_MAX)
            begin
                sem_count[id] = sem_count[id] + 16'd1;
            end
            for (w = 0; w < WAITER_SLOTS; w++)
            begin
                if (hit < 0 && waiter_busy[id][w])
                begin
                    hit = w;
                end
            end
            r.status = ST_OK;
            if (hit >= 0)
            begin
                waiter_busy[id][hit] = 1'b0;
                r.wake_valid         = 1'b1;
                r.wake_pid           = waiter_owner[id][hit];
            end
        end
        else if (sem_count[id] != 16'd0)
        begin
            sem_count[id] = sem_count[id] - 16'd1;
            r.status      = ST_OK;
        end
        else
        begin
            for (w = 0; w < WAITER_SLOTS; w++)
            begin
                if (free_w < 0 && !waiter_busy[id][w])
                begin
                    free_w = w;
                end
            end
            if (free_w < 0)
            begin
                r.status = ST_NO_WAITER;
            end
            else
            begin
                r.yield_request = 1'b1;
                r.status        = ST_OK;
                if (c.caller_can_block)
                begin
                    waiter_busy[id][free_w]  = 1'b1;
                    waiter_owner[id][free_w] = c.caller_pid;
                    r.block_valid            = 1'b1;
                    r.status                 = ST_BLOCKED;
                end
            end
        end
        return r;
    endfunction

    function automatic void queue_cmd(logic [1:0] op, logic [63:0] key, logic [3:0] id,
                                      logic [7:0] pid, logic blk);
        cst_cmd_t c;
        c.operation        = op;
        c.name_key         = key;
        c.target_id        = id;
        c.caller_pid       = pid;
        c.caller_can_block = blk;
        pending_cmds.push_back(c);
    endfunction

    function automatic void report_failure(string what, cst_rsp_t want, cst_rsp_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%s at result %0d: expected st=%0d id=%0d wake=%0b/%02h blk=%0b yld=%0b",
                     what, rsp_count, want.status, want.result_id, want.wake_valid,
                     want.wake_pid, want.block_valid, want.yield_request);
            $display("    got st=%0d id=%0d wake=%0b/%02h blk=%0b yld=%0b",
                     got.status, got.result_id, got.wake_valid, got.wake_pid,
                     got.block_valid, got.yield_request);
        end
    endfunction

    function automatic void check_result(cst_rsp_t got);
        cst_rsp_t want;
        bit       bad;
        if (expected_rsp.size() == 0)
        begin
            report_failure("Unexpected result", '0, got);
        end
        else
        begin
            want = expected_rsp.pop_front();
            bad  = (got.status !== want.status) || (got.result_id !== want.result_id) ||
                   (got.wake_valid !== want.wake_valid) || (got.wake_pid !== want.wake_pid) ||
                   (got.block_valid !== want.block_valid) ||
                   (got.yield_request !== want.yield_request);
            if (bad)
            begin
                report_failure("Mismatch", want, got);
            end
        end
        rsp_count++;
    endfunction

    // Key-pool open bursts, lone closes, wait or post bursts on one id, and random items.
    task automatic queue_random_items(input int total);
        int          queued;
        int          pick;
        int          burst;
        int          n;
        bit          noise;
        logic [1:0]  op;
        logic [3:0]  id;
        logic [63:0] key;
        queued = 0;
        while (queued < total)
        begin
            pick  = $urandom_range(99);
            id    = 4'($urandom_range(SEM_SLOTS - 1));
            noise = 1'b0;
            op    = OP_OPEN;
            if (pick < 22)
            begin
                burst = $urandom_range(3, 1);
            end
            else if (pick < 30)
            begin
                op    = OP_CLOSE;
                burst = 1;
            end
            else if (pick < 60)
            begin
                op    = OP_WAIT;
                burst = $urandom_range(24, 1);
            end
            else if (pick < 90)
            begin
                op    = OP_POST;
                burst = $urandom_range(20, 1);
            end
            else
            begin
                noise = 1'b1;
                burst = $urandom_range(2, 1);
            end
            for (n = 0; n < burst && queued < total; n++)
            begin
                key = {$urandom, $urandom};
                if (noise)
                begin
                    queue_cmd(2'($urandom_range(3)), key, 4'($urandom_range(15)),
                              8'($urandom_range(255)), 1'($urandom_range(1)));
                end
                else if (op == OP_OPEN)
                begin
                    queue_cmd(op, key_pool[$urandom_range(KEY_POOL - 1)],
                              4'($urandom_range(15)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
                end
                else
                begin
                    queue_cmd(op, key, id, 8'($urandom_range(255)), $urandom_range(99) < 85);
                end
                queued++;
            end
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || cmd_valid || expected_rsp.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            cmd       <= '0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_rsp.push_back(semaphore_apply(cmd));
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cmd_valid <= 1'b1;
                    cmd       <= pending_cmds.pop_front();
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                check_result(rsp);
            end
            rsp_stall <= rx_hold || ($urandom_range(99) < rx_stall_pct);
        end
    end

    // Long receiver hold-off so that the output register fills and the input stalls.
    always
    begin
        @(rx_hold_start);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("** counting_semaphore_table: FAILED **");
        $finish;
    end

    initial
    begin
        int k;
        int phase;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 64'h8000_0000_0000_0000;
        key_pool[3] = 64'h0000_0000_0000_0001;
        for (k = 4; k < KEY_POOL; k++)
        begin
            key_pool[k] = {$urandom, $urandom};
        end
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Unused ids, reopen of a live name, blocking and non-blocking waits, wakeups, close.
        queue_cmd(OP_POST, '0, 4'd0, 8'h00, 1'b1);
        queue_cmd(OP_WAIT, '1, 4'd15, 8'h5A, 1'b1);
        queue_cmd(OP_CLOSE, '0, 4'd7, 8'h00, 1'b0);
        queue_cmd(OP_OPEN, '1, 4'd9, 8'hFF, 1'b1);
        queue_cmd(OP_OPEN, '0, 4'd0, 8'h00, 1'b0);
        queue_cmd(OP_OPEN, '1, 4'd3, 8'h00, 1'b0);
        queue_cmd(OP_WAIT, '0, 4'd0, 8'h11, 1'b1);
        queue_cmd(OP_WAIT, '0, 4'd0, 8'hFF, 1'b1);
        queue_cmd(OP_WAIT, '0, 4'd0, 8'h00, 1'b0);
        queue_cmd(OP_WAIT, '0, 4'd0, 8'hA5, 1'b1);
        queue_cmd(OP_POST, '0, 4'd0, 8'h00, 1'b0);
        queue_cmd(OP_POST, '0, 4'd0, 8'h00, 1'b0);
        queue_cmd(OP_POST, '0, 4'd0, 8'h00, 1'b0);
        queue_cmd(OP_WAIT, '0, 4'd1, 8'h3C, 1'b1);
        queue_cmd(OP_WAIT, '0, 4'd1, 8'h42, 1'b1);
        queue_cmd(OP_CLOSE, '0, 4'd1, 8'h00, 1'b0);
        queue_cmd(OP_POST, '0, 4'd1, 8'h00, 1'b0);
        queue_cmd(OP_OPEN, 64'h8000_0000_0000_0000, 4'd0, 8'h00, 1'b0);
        queue_cmd(OP_POST, '0, 4'd1, 8'h00, 1'b0);
        queue_cmd(OP_OPEN, '1, 4'd0, 8'h00, 1'b0);
        wait_drained();

        // A run of posts on slot 0, then one step down and back up.
        for (k = 0; k < 48; k++)
        begin
            queue_cmd(OP_POST, '0, 4'd0, 8'h00, 1'b0);
        end
        queue_cmd(OP_WAIT, '0, 4'd0, 8'h77, 1'b1);
        queue_cmd(OP_POST, '0, 4'd0, 8'h00, 1'b0);
        queue_cmd(OP_POST, '0, 4'd0, 8'h00, 1'b0);
        wait_drained();

        // Full table, then a full waiter row on slot 2.
        for (k = 4; k < 19; k++)
        begin
            queue_cmd(OP_OPEN, key_pool[k], 4'd0, 8'h00, 1'b0);
        end
        for (k = 0; k < 18; k++)
        begin
            queue_cmd(OP_WAIT, '0, 4'd2, k[7:0] + 8'h80, 1'b1);
        end
        queue_cmd(OP_POST, '0, 4'd2, 8'h00, 1'b0);
        queue_cmd(OP_CLOSE, '0, 4'd5, 8'h00, 1'b0);
        queue_cmd(OP_OPEN, key_pool[18], 4'd0, 8'h00, 1'b0);
        wait_drained();

        for (phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = (phase == 1) ? 65 : (phase == 3) ? 22 : 0;
            rx_stall_pct  = (phase == 2) ? 65 : (phase == 3) ? 22 : 0;
            queue_random_items(320);
            wait_drained();
        end

        send_idle_pct = 0;
        rx_stall_pct  = 0;
        -> rx_hold_start;
        queue_random_items(40);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_rsp.size() == 0)
        begin
            $display("** counting_semaphore_table: PASSED **");
        end
        else
        begin
            $display("** counting_semaphore_table: FAILED **");
        end
        $finish;
    end

endmodule
